// File: hdl/s2crdz_pkg.sv
// Shared types, constants and helper functions for the stick-to-cursor block.
package s2crdz_pkg;

	localparam int XY_W       = 16;
	localparam int DZ_W       = 15;
	localparam int GAIN_W     = 16;
	localparam int DELTA_W    = 7;
	localparam int TOT_W      = 32;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int CNT_W      = 6;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = CFG_IDX_W'(1);

	localparam logic [DZ_W-1:0]   DZ_RESET   = DZ_W'(3277);
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(27307);

	// Normalized magnitude is capped at 4.0 in Q16.
	localparam logic [18:0] NMAG_CAP = 19'd262144;

	localparam logic [CNT_W-1:0] MUL_STEPS  = CNT_W'(17);
	localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(18);
	localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(32);

	localparam logic signed [DELTA_W-1:0] DELTA_MAX = 7'sd63;
	localparam logic signed [DELTA_W-1:0] DELTA_MIN = 7'sb1000000;
	localparam logic signed [TOT_W-1:0]   TOT_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [TOT_W-1:0]   TOT_MIN   = 32'sh8000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULX,
		ST_MULY,
		ST_SQRT_M,
		ST_DIV_N,
		ST_SQRT_S,
		ST_SQRT_Q,
		ST_MUL_A,
		ST_MUL_T,
		ST_MUL_PX,
		ST_DIV_X,
		ST_MUL_PY,
		ST_DIV_Y,
		ST_OUT
	} state_t;

	// Number of serial steps the active arithmetic unit runs in each state.
	function automatic logic [CNT_W-1:0] step_count(input state_t st);
		logic [CNT_W-1:0] n;
		case (st)
			ST_MULX, ST_MULY, ST_MUL_A, ST_MUL_T, ST_MUL_PX, ST_MUL_PY: n = MUL_STEPS;
			ST_SQRT_M, ST_SQRT_S, ST_SQRT_Q: n = SQRT_STEPS;
			ST_DIV_N, ST_DIV_X, ST_DIV_Y: n = DIV_STEPS;
			default: n = '0;
		endcase
		return n;
	endfunction

	// Turns an unsigned quotient and a sign into a saturated pixel step.
	function automatic logic signed [DELTA_W-1:0] axis_delta(input logic [31:0] quo,
			input logic neg);
		logic [5:0] mag;
		logic signed [DELTA_W-1:0] res;
		mag = quo[5:0];
		if (|quo[31:6])
			res = neg ? DELTA_MIN : DELTA_MAX;
		else if (neg)
			res = -$signed({1'b0, mag});
		else
			res = $signed({1'b0, mag});
		return res;
	endfunction

	function automatic logic signed [TOT_W-1:0] sat_add(input logic signed [TOT_W-1:0] acc,
			input logic signed [DELTA_W-1:0] d);
		logic [TOT_W:0] s;
		logic signed [TOT_W-1:0] res;
		s = {acc[TOT_W-1], acc} + {{(TOT_W + 1 - DELTA_W){d[DELTA_W-1]}}, d};
		if (s[TOT_W] != s[TOT_W-1])
			res = s[TOT_W] ? TOT_MIN : TOT_MAX;
		else
			res = $signed(s[TOT_W-1:0]);
		return res;
	endfunction

endpackage

// File: hdl/stick_to_cursor_radial_deadzone.sv
// Top level of the analog stick to cursor converter with radial deadzone and power curve.
//
// One stick sample request yields one result. A sample taken while the menu is
// inactive gives a zero step with no arithmetic; a sample inside the deadzone
// stops with a zero step after the magnitude; any other sample runs the full
// sequence, and the block is ready for the next sample the cycle after the
// result is loaded. The work is done by one sequencer that runs a shared
// bit-serial shift-and-add multiplier (17 steps), a two-bits-per-step square
// root unit (18 steps) and a restoring divider (32 steps) over the magnitude,
// normalization, 1.25 power curve, gain and per-axis direction. A finished
// result sits in an output register, so the next sample can be taken while it waits.
module stick_to_cursor_radial_deadzone (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [s2crdz_pkg::XY_W-1:0]       stick_x,
	input  logic signed [s2crdz_pkg::XY_W-1:0]       stick_y,
	input  logic                                     menu_active,
	input  logic                                     clear_accum,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [s2crdz_pkg::DELTA_W-1:0]    delta_x,
	output logic signed [s2crdz_pkg::DELTA_W-1:0]    delta_y,
	output logic                                     moved,
	output logic signed [s2crdz_pkg::TOT_W-1:0]      total_x,
	output logic signed [s2crdz_pkg::TOT_W-1:0]      total_y,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [s2crdz_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [s2crdz_pkg::CFG_DATA_W-1:0]        cfg_data
);

	s2crdz_pkg::state_t state_q, state_d;
	logic [s2crdz_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic done;

	logic [s2crdz_pkg::DZ_W-1:0]   dz_q;
	logic [s2crdz_pkg::GAIN_W-1:0] gain_q;

	// Shared multiplier: multiplicand, multiplier shifted out LSB first, product.
	logic [34:0] mcand_q, mcand_d;
	logic [16:0] mplier_q, mplier_d;
	logic [51:0] prod_q;
	logic [35:0] mul_sum;
	logic        mul_ld, mul_run;

	// Square root unit: radicand shifted out two bits a step.
	logic [35:0] rad_q, rad_d;
	logic [17:0] sroot_q;
	logic [19:0] srem_q;
	logic [21:0] sq_r2, sq_trial;
	logic        sq_ld, sq_run, sq_ge;

	// Divider: numerator shifts out at the top while quotient bits shift in.
	logic [31:0] dnum_q, dnum_d;
	logic [15:0] dden_q, dden_d;
	logic [15:0] drem_q;
	logic [16:0] dv_r;
	logic        dv_ld, dv_run, dv_ge;

	logic [15:0] abs_x, abs_y;
	logic [15:0] ax_q, ay_q;
	logic        negx_q, negy_q;
	logic [31:0] m2x_q;
	logic [15:0] m_q;
	logic [18:0] n_q, n_cap;
	logic [34:0] t_q;
	logic signed [s2crdz_pkg::DELTA_W-1:0] dx_q, dy_q;
	logic take_in, out_ld, save_m2x, save_m, save_n, save_t, save_dx, save_dy, zero_d;
	logic moved_d;
	logic signed [s2crdz_pkg::TOT_W-1:0] sum_x_q, sum_y_q, sum_x_d, sum_y_d;

	logic signed [s2crdz_pkg::DELTA_W-1:0] delta_x_q, delta_y_q;
	logic moved_q, out_valid_q;
	logic signed [s2crdz_pkg::TOT_W-1:0] total_x_q, total_y_q;

	assign in_stall  = (state_q != s2crdz_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign delta_x   = delta_x_q;
	assign delta_y   = delta_y_q;
	assign moved     = moved_q;
	assign total_x   = total_x_q;
	assign total_y   = total_y_q;

	assign abs_x = stick_x[15] ? (~stick_x + 16'd1) : stick_x;
	assign abs_y = stick_y[15] ? (~stick_y + 16'd1) : stick_y;

	assign done = (cnt_q == s2crdz_pkg::step_count(state_q));

	assign mul_run = !done && (state_q inside {s2crdz_pkg::ST_MULX, s2crdz_pkg::ST_MULY,
		s2crdz_pkg::ST_MUL_A, s2crdz_pkg::ST_MUL_T, s2crdz_pkg::ST_MUL_PX,
		s2crdz_pkg::ST_MUL_PY});
	assign sq_run = !done && (state_q inside {s2crdz_pkg::ST_SQRT_M, s2crdz_pkg::ST_SQRT_S,
		s2crdz_pkg::ST_SQRT_Q});
	assign dv_run = !done && (state_q inside {s2crdz_pkg::ST_DIV_N, s2crdz_pkg::ST_DIV_X,
		s2crdz_pkg::ST_DIV_Y});

	assign mul_sum  = {1'b0, prod_q[51:17]} + (mplier_q[0] ? {1'b0, mcand_q} : 36'd0);
	assign sq_r2    = {srem_q, rad_q[35:34]};
	assign sq_trial = {2'b00, sroot_q, 2'b01};
	assign sq_ge    = (sq_r2 >= sq_trial);
	assign dv_r     = {drem_q, dnum_q[31]};
	assign dv_ge    = (dv_r >= {1'b0, dden_q});

	assign n_cap = (dnum_q > 32'(s2crdz_pkg::NMAG_CAP)) ? s2crdz_pkg::NMAG_CAP : dnum_q[18:0];

	assign moved_d = (dx_q != '0) || (dy_q != '0);
	assign sum_x_d = moved_d ? s2crdz_pkg::sat_add(sum_x_q, dx_q) : sum_x_q;
	assign sum_y_d = moved_d ? s2crdz_pkg::sat_add(sum_y_q, dy_q) : sum_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= s2crdz_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Each arithmetic state runs its unit for the step count, then hands the
	// result to the next unit when the count is reached.
	always_comb begin
		state_d  = state_q;
		cnt_d    = '0;
		mul_ld   = 1'b0;
		mcand_d  = '0;
		mplier_d = '0;
		sq_ld    = 1'b0;
		rad_d    = '0;
		dv_ld    = 1'b0;
		dnum_d   = '0;
		dden_d   = '0;
		take_in  = 1'b0;
		out_ld   = 1'b0;
		save_m2x = 1'b0;
		save_m   = 1'b0;
		save_n   = 1'b0;
		save_t   = 1'b0;
		save_dx  = 1'b0;
		save_dy  = 1'b0;
		zero_d   = 1'b0;
		if (!done)
			cnt_d = cnt_q + 1'b1;
		case (state_q)
			s2crdz_pkg::ST_IDLE: begin
				if (in_valid) begin
					take_in = 1'b1;
					if (menu_active) begin
						mul_ld   = 1'b1;
						mcand_d  = 35'(abs_x);
						mplier_d = 17'(abs_x);
						state_d  = s2crdz_pkg::ST_MULX;
					end else begin
						zero_d  = 1'b1;
						state_d = s2crdz_pkg::ST_OUT;
					end
				end
			end
			s2crdz_pkg::ST_MULX: begin
				if (done) begin
					save_m2x = 1'b1;
					mul_ld   = 1'b1;
					mcand_d  = 35'(ay_q);
					mplier_d = 17'(ay_q);
					state_d  = s2crdz_pkg::ST_MULY;
				end
			end
			s2crdz_pkg::ST_MULY: begin
				if (done) begin
					sq_ld   = 1'b1;
					rad_d   = 36'(33'(m2x_q) + 33'(prod_q[31:0]));
					state_d = s2crdz_pkg::ST_SQRT_M;
				end
			end
			s2crdz_pkg::ST_SQRT_M: begin
				if (done) begin
					// Inside the deadzone, or no direction at all: no movement.
					if (sroot_q[15:0] == '0 || sroot_q[15:0] < {1'b0, dz_q}) begin
						zero_d  = 1'b1;
						state_d = s2crdz_pkg::ST_OUT;
					end else begin
						save_m  = 1'b1;
						dv_ld   = 1'b1;
						dnum_d  = {sroot_q[15:0] - {1'b0, dz_q}, 16'd0};
						dden_d  = 16'(17'd32768 - 17'(dz_q));
						state_d = s2crdz_pkg::ST_DIV_N;
					end
				end
			end
			s2crdz_pkg::ST_DIV_N: begin
				if (done) begin
					save_n  = 1'b1;
					sq_ld   = 1'b1;
					rad_d   = 36'({n_cap, 16'd0});
					state_d = s2crdz_pkg::ST_SQRT_S;
				end
			end
			s2crdz_pkg::ST_SQRT_S: begin
				if (done) begin
					sq_ld   = 1'b1;
					rad_d   = 36'({sroot_q, 16'd0});
					state_d = s2crdz_pkg::ST_SQRT_Q;
				end
			end
			s2crdz_pkg::ST_SQRT_Q: begin
				if (done) begin
					mul_ld   = 1'b1;
					mcand_d  = 35'(n_q);
					mplier_d = sroot_q[16:0];
					state_d  = s2crdz_pkg::ST_MUL_A;
				end
			end
			s2crdz_pkg::ST_MUL_A: begin
				if (done) begin
					mul_ld   = 1'b1;
					mcand_d  = 35'(prod_q[34:16]);
					mplier_d = 17'(gain_q);
					state_d  = s2crdz_pkg::ST_MUL_T;
				end
			end
			s2crdz_pkg::ST_MUL_T: begin
				if (done) begin
					save_t   = 1'b1;
					mul_ld   = 1'b1;
					mcand_d  = prod_q[34:0];
					mplier_d = 17'(ax_q);
					state_d  = s2crdz_pkg::ST_MUL_PX;
				end
			end
			s2crdz_pkg::ST_MUL_PX: begin
				if (done) begin
					dv_ld   = 1'b1;
					dnum_d  = 32'(prod_q[50:28]);
					dden_d  = m_q;
					state_d = s2crdz_pkg::ST_DIV_X;
				end
			end
			s2crdz_pkg::ST_DIV_X: begin
				if (done) begin
					save_dx  = 1'b1;
					mul_ld   = 1'b1;
					mcand_d  = t_q;
					mplier_d = 17'(ay_q);
					state_d  = s2crdz_pkg::ST_MUL_PY;
				end
			end
			s2crdz_pkg::ST_MUL_PY: begin
				if (done) begin
					dv_ld   = 1'b1;
					dnum_d  = 32'(prod_q[50:28]);
					dden_d  = m_q;
					state_d = s2crdz_pkg::ST_DIV_Y;
				end
			end
			s2crdz_pkg::ST_DIV_Y: begin
				if (done) begin
					save_dy = 1'b1;
					state_d = s2crdz_pkg::ST_OUT;
				end
			end
			s2crdz_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_ld  = 1'b1;
					state_d = s2crdz_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = s2crdz_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q        <= s2crdz_pkg::DZ_RESET;
			gain_q      <= s2crdz_pkg::GAIN_RESET;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					s2crdz_pkg::CFG_DEADZONE: dz_q   <= cfg_data[s2crdz_pkg::DZ_W-1:0];
					s2crdz_pkg::CFG_GAIN:     gain_q <= cfg_data;
					default: ;
				endcase
			end
			if (take_in && clear_accum) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
			end else if (out_ld) begin
				sum_x_q <= sum_x_d;
				sum_y_q <= sum_y_d;
			end
			if (out_ld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_ld) begin
			mcand_q  <= mcand_d;
			mplier_q <= mplier_d;
			prod_q   <= '0;
		end else if (mul_run) begin
			prod_q   <= {mul_sum, prod_q[16:1]};
			mplier_q <= {1'b0, mplier_q[16:1]};
		end

		if (sq_ld) begin
			rad_q   <= rad_d;
			sroot_q <= '0;
			srem_q  <= '0;
		end else if (sq_run) begin
			rad_q   <= {rad_q[33:0], 2'b00};
			srem_q  <= sq_ge ? 20'(sq_r2 - sq_trial) : sq_r2[19:0];
			sroot_q <= {sroot_q[16:0], sq_ge};
		end

		if (dv_ld) begin
			dnum_q <= dnum_d;
			dden_q <= dden_d;
			drem_q <= '0;
		end else if (dv_run) begin
			drem_q <= dv_ge ? 16'(dv_r - {1'b0, dden_q}) : dv_r[15:0];
			dnum_q <= {dnum_q[30:0], dv_ge};
		end

		if (take_in) begin
			ax_q   <= abs_x;
			ay_q   <= abs_y;
			negx_q <= stick_x[15];
			negy_q <= stick_y[15];
		end
		if (save_m2x)
			m2x_q <= prod_q[31:0];
		if (save_m)
			m_q <= sroot_q[15:0];
		if (save_n)
			n_q <= n_cap;
		if (save_t)
			t_q <= prod_q[34:0];
		if (zero_d) begin
			dx_q <= '0;
			dy_q <= '0;
		end
		if (save_dx)
			dx_q <= s2crdz_pkg::axis_delta(dnum_q, negx_q);
		if (save_dy)
			dy_q <= s2crdz_pkg::axis_delta(dnum_q, negy_q);

		if (out_ld) begin
			delta_x_q <= dx_q;
			delta_y_q <= dy_q;
			moved_q   <= moved_d;
			total_x_q <= sum_x_d;
			total_y_q <= sum_y_d;
		end
	end

endmodule

// File: hdl/s2crdz_checker.sv
// Port-level checker for the stick-to-cursor block and its bind statement.
module s2crdz_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_stall,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic signed [s2crdz_pkg::DELTA_W-1:0] delta_x,
	input logic signed [s2crdz_pkg::DELTA_W-1:0] delta_y,
	input logic                                  moved,
	input logic signed [s2crdz_pkg::TOT_W-1:0]   total_x
);

	// The block works on one request at a time, so it stalls right after taking one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a request was accepted");

	// Moved reports exactly whether either step is nonzero.
	a_moved_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (moved == (delta_x != '0 || delta_y != '0)))
		else $error("moved flag disagrees with the deltas");

	// A new result appears only after the block was busy with a request.
	a_result_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a request in progress");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(delta_x) && $stable(total_x))
		else $error("stalled result changed");

endmodule

bind stick_to_cursor_radial_deadzone s2crdz_checker u_s2crdz_checker (.*);

// File: bench/tb_stick_to_cursor_radial_deadzone.sv
// Self-checking testbench for the stick-to-cursor radial deadzone block.
module tb_stick_to_cursor_radial_deadzone;
	timeunit 1ns;
	timeprecision 1ps;

	import s2crdz_pkg::*;

	// An index that maps to no register; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(14);
	localparam int ITEMS_PER_BLOCK = 80;

	typedef struct {
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic                      moved;
		logic signed [TOT_W-1:0]   tx;
		logic signed [TOT_W-1:0]   ty;
	} cursor_step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [XY_W-1:0] stick_x = '0;
	logic signed [XY_W-1:0] stick_y = '0;
	logic menu_active = 1'b0;
	logic clear_accum = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DELTA_W-1:0] delta_x;
	logic signed [DELTA_W-1:0] delta_y;
	logic moved;
	logic signed [TOT_W-1:0] total_x;
	logic signed [TOT_W-1:0] total_y;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the block's registers and accumulators.
	logic [DZ_W-1:0] shadow_deadzone = DZ_RESET;
	logic [GAIN_W-1:0] shadow_gain = GAIN_RESET;
	int acc_x = 0;
	int acc_y = 0;

	cursor_step_t pending_steps[$];
	cursor_step_t want;
	int gap_pct = 0;
	int stall_pct = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int moves_seen = 0;
	int mismatches = 0;

	stick_to_cursor_radial_deadzone uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stick_x(stick_x),
		.stick_y(stick_y),
		.menu_active(menu_active),
		.clear_accum(clear_accum),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.delta_x(delta_x),
		.delta_y(delta_y),
		.moved(moved),
		.total_x(total_x),
		.total_y(total_y),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned trial;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = r | (64'd1 << b);
			if (trial * trial <= v)
				r = trial;
		end
		return r;
	endfunction

	function automatic int pixel_step(input int c, input longint unsigned gain_term,
			input longint unsigned mag);
		longint unsigned ac;
		longint unsigned quo;
		ac = (c < 0) ? longint'(-c) : longint'(c);
		quo = (ac * gain_term) / (mag << 28);
		if (c < 0)
			return (quo >= 64) ? -64 : -int'(quo);
		return (quo > 63) ? 63 : int'(quo);
	endfunction

	function automatic int clamp_total(input int acc, input int d);
		longint s;
		s = longint'(acc) + longint'(d);
		if (s > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (s < -64'sd2147483648)
			return 32'sh8000_0000;
		return int'(s);
	endfunction

	// Works out the cursor step for one sample and advances the shadow accumulators.
	function automatic cursor_step_t predict_cursor(input int x, input int y, input bit menu,
			input bit clr);
		cursor_step_t r;
		longint unsigned m2, dz, m, n, s, q, a, t;
		int dx, dy;
		dx = 0;
		dy = 0;
		if (clr) begin
			acc_x = 0;
			acc_y = 0;
		end
		if (menu) begin
			m2 = longint'(x * x) + longint'(y * y);
			dz = shadow_deadzone;
			if (m2 >= dz * dz) begin
				m = floor_sqrt(m2);
				if (m != 0) begin
					n = ((m - dz) << 16) / (64'd32768 - dz);
					if (n > NMAG_CAP)
						n = NMAG_CAP;
					s = floor_sqrt(n << 16);
					q = floor_sqrt(s << 16);
					a = (n * q) >> 16;
					t = a * shadow_gain;
					dx = pixel_step(x, t, m);
					dy = pixel_step(y, t, m);
				end
			end
		end
		r.moved = (dx != 0) || (dy != 0);
		if (r.moved) begin
			acc_x = clamp_total(acc_x, dx);
			acc_y = clamp_total(acc_y, dy);
		end
		r.dx = dx[DELTA_W-1:0];
		r.dy = dy[DELTA_W-1:0];
		r.tx = acc_x;
		r.ty = acc_y;
		return r;
	endfunction

	task automatic flag_mismatch(input string field, input longint got, input longint exp_val);
		mismatches++;
		if (mismatches <= 40)
			$display("result %0d: %s is %0d, expected %0d", results_seen, field, got, exp_val);
	endtask

	// Receiver side: random stall and the result check.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_steps.size() == 0) begin
				flag_mismatch("unexpected result, pending count", 1, 0);
			end else begin
				want = pending_steps.pop_front();
				if (moved)
					moves_seen++;
				if (delta_x !== want.dx)
					flag_mismatch("delta_x", delta_x, want.dx);
				if (delta_y !== want.dy)
					flag_mismatch("delta_y", delta_y, want.dy);
				if (moved !== want.moved)
					flag_mismatch("moved", moved, want.moved);
				if (total_x !== want.tx)
					flag_mismatch("total_x", total_x, want.tx);
				if (total_y !== want.ty)
					flag_mismatch("total_y", total_y, want.ty);
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Sends one stick sample; valid stays high after acceptance until the next call or a drain.
	task automatic push_sample(input int x, input int y, input bit menu, input bit clr);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		stick_x <= x[XY_W-1:0];
		stick_y <= y[XY_W-1:0];
		menu_active <= menu;
		clear_accum <= clr;
		pending_steps.push_back(predict_cursor(x, y, menu, clr));
		samples_sent++;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic drain(input int settle);
		in_valid <= 1'b0;
		while (pending_steps.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_DEADZONE)
			shadow_deadzone = val[DZ_W-1:0];
		else if (idx == CFG_GAIN)
			shadow_gain = val;
		@(posedge clk);
	endtask

	task automatic check_default_settings();
		push_sample(0, 0, 1'b1, 1'b0);
		push_sample(32767, 0, 1'b1, 1'b0);
		push_sample(-32768, 0, 1'b1, 1'b0);
		push_sample(0, 32767, 1'b1, 1'b0);
		push_sample(0, -32768, 1'b1, 1'b0);
		push_sample(-32768, -32768, 1'b1, 1'b0);
		push_sample(32767, 32767, 1'b1, 1'b0);
		push_sample(32767, -32768, 1'b0, 1'b0);
		push_sample(20000, 20000, 1'b0, 1'b1);
		push_sample(3277, 0, 1'b1, 1'b0);
		push_sample(3276, 0, 1'b1, 1'b0);
		push_sample(1000, -30000, 1'b1, 1'b1);
		push_sample(-9000, 7000, 1'b1, 1'b0);
		drain(8);
	endtask

	task automatic check_deadzone_extremes();
		write_reg(CFG_DEADZONE, 16'd0);
		push_sample(0, 0, 1'b1, 1'b0);
		push_sample(1, 0, 1'b1, 1'b0);
		push_sample(-1, -1, 1'b1, 1'b0);
		drain(8);
		// Bit 15 of the data has no place in the register.
		write_reg(CFG_DEADZONE, 16'hFFFF);
		push_sample(-32768, -32768, 1'b1, 1'b0);
		push_sample(32767, 0, 1'b1, 1'b0);
		push_sample(32767, 32767, 1'b1, 1'b0);
		drain(8);
	endtask

	task automatic check_gain_extremes();
		write_reg(CFG_DEADZONE, 16'd3277);
		write_reg(CFG_GAIN, 16'hFFFF);
		push_sample(32767, 100, 1'b1, 1'b0);
		push_sample(-32768, -32768, 1'b1, 1'b0);
		drain(8);
		write_reg(CFG_GAIN, 16'd0);
		push_sample(-32768, 32767, 1'b1, 1'b0);
		drain(8);
	endtask

	task automatic check_spare_index();
		write_reg(CFG_GAIN, GAIN_RESET);
		write_reg(CFG_SPARE, 16'h0000);
		write_reg(CFG_SPARE, 16'hFFFF);
		push_sample(25000, -12000, 1'b1, 1'b0);
		push_sample(-4000, 4000, 1'b1, 1'b1);
		drain(8);
	endtask

	function automatic int pick_axis(input int mode);
		int r;
		case (mode)
			0: begin
				case ($urandom_range(4))
					0: return -32768;
					1: return -1;
					2: return 0;
					3: return 1;
					default: return 32767;
				endcase
			end
			1: begin
				r = int'(shadow_deadzone) + 600;
				r = $urandom_range(2 * r) - r;
				return (r > 32767) ? 32767 : ((r < -32768) ? -32768 : r);
			end
			default: return $signed(16'($urandom));
		endcase
	endfunction

	task automatic run_random_traffic();
		int mode;
		int pct;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 56; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 56; end
				default: begin gap_pct = 19; stall_pct = 19; end
			endcase
			for (int blk = 0; blk < 2; blk++) begin
				case ($urandom_range(5))
					0: write_reg(CFG_DEADZONE, 16'd0);
					1: write_reg(CFG_DEADZONE, 16'd32767);
					2: write_reg(CFG_DEADZONE, 16'($urandom_range(1, 16383)));
					default: write_reg(CFG_DEADZONE, 16'($urandom_range(500, 8000)));
				endcase
				case ($urandom_range(3))
					0: write_reg(CFG_GAIN, 16'hFFFF);
					1: write_reg(CFG_GAIN, 16'($urandom_range(0, 4095)));
					default: write_reg(CFG_GAIN, 16'($urandom_range(4096, 65535)));
				endcase
				for (int i = 0; i < ITEMS_PER_BLOCK; i++) begin
					pct = $urandom_range(99);
					mode = (pct < 10) ? 0 : ((pct < 40) ? 1 : 2);
					push_sample(pick_axis(mode), pick_axis(mode), $urandom_range(99) < 85,
							$urandom_range(99) < 5);
				end
				drain(8);
			end
		end
		gap_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_default_settings();
		check_deadzone_extremes();
		check_gain_extremes();
		check_spare_index();
		run_random_traffic();
		drain(300);
		if (pending_steps.size() != 0)
			flag_mismatch("results never delivered", 0, pending_steps.size());
		$display("Sent %0d stick samples over four handshake pacing modes and several settings;",
				samples_sent);
		$display("checked %0d results, %0d of them with cursor movement.", results_seen,
				moves_seen);
		if (mismatches == 0)
			$display("stick_to_cursor_radial_deadzone: match");
		else
			$display("stick_to_cursor_radial_deadzone: mismatch");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("Run stopped: time limit reached with %0d results pending.",
				pending_steps.size());
		$display("stick_to_cursor_radial_deadzone: mismatch");
		$finish;
	end

endmodule

// File: stick_to_cursor_radial_deadzone.f
hdl/s2crdz_pkg.sv
hdl/stick_to_cursor_radial_deadzone.sv
hdl/s2crdz_checker.sv
bench/tb_stick_to_cursor_radial_deadzone.sv
